/* hdl/timer_prescaler_period_solver_core_assert.svh */
// Assertion helpers; expect clk and arst_n in scope.
`ifndef TIMER_PRESCALER_PERIOD_SOLVER_CORE_ASSERT_SVH
`define TIMER_PRESCALER_PERIOD_SOLVER_CORE_ASSERT_SVH

// ante holds -> cons holds at the same edge
`define TPPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond must never hold
`define TPPS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* hdl/tpps_pkg.sv */
`default_nettype none
package tpps_pkg;

	localparam int DIV_W    = 32;
	localparam int PERIOD_W = 16;
	localparam int CODE_W   = 2;
	localparam int IDX_W    = 2;

	localparam logic [DIV_W-1:0] SYSCLK_RST  = 32'd200000000;
	localparam logic [DIV_W-1:0] MIN_RATE_RST = 32'd1000;
	localparam logic [DIV_W-1:0] MAX_RATE_RST = 32'd105000000;

	typedef enum logic [IDX_W-1:0] {
		REG_SYSCLK   = 2'd0,
		REG_MIN_RATE = 2'd1,
		REG_MAX_RATE = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		PSC_DIV1  = 2'd0,
		PSC_DIV4  = 2'd1,
		PSC_DIV16 = 2'd2,
		PSC_DIV64 = 2'd3
	} psc_code_t;

	// one division step in flight
	typedef struct packed {
		logic             vld;
		logic             in_range;
		logic [DIV_W-1:0] dividend;  // remaining dividend bits, msb next
		logic [DIV_W-1:0] divisor;
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] quo;
	} div_stage_t;

endpackage
`default_nettype wire

/* hdl/timer_prescaler_period_solver_core.sv */
`default_nettype none
// Prescaler/period solver. Fully pipelined: busy stays low, one request may be
// issued on start every cycle, and its result appears on done after passing one
// entry stage with the range check, a row of 32 one-bit division cells for
// system_clock_hz / req_rate, and one stage picking the prescaler. done pulses
// for one cycle and the result must be taken then; there is no stall. Write the
// config registers only while no request is in flight.
module timer_prescaler_period_solver_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [tpps_pkg::DIV_W-1:0]      req_rate,
	input  wire logic                            cfg_we,
	input  wire logic [tpps_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [tpps_pkg::DIV_W-1:0]      cfg_wdata,
	output logic                                 done,
	output logic                                 valid_res,
	output logic [tpps_pkg::CODE_W-1:0]          prescaler_code,
	output logic [tpps_pkg::PERIOD_W-1:0]        period_val
);

	localparam int N_CELLS = tpps_pkg::DIV_W;
	localparam int LATENCY = N_CELLS + 2;

	logic [tpps_pkg::DIV_W-1:0] sysclk_q, min_rate_q, max_rate_q;
	tpps_pkg::div_stage_t       entry_s1;
	tpps_pkg::div_stage_t       chain [N_CELLS+1];
	logic                       in_range;
	logic                       in_acc;

	logic                          done_q, valid_q;
	logic [tpps_pkg::CODE_W-1:0]   code_q;
	logic [tpps_pkg::PERIOD_W-1:0] period_q;
	logic                          sel_valid;
	tpps_pkg::psc_code_t           sel_code;
	logic [tpps_pkg::PERIOD_W-1:0] sel_period;
	logic [tpps_pkg::DIV_W-1:0]    quo;

	assign busy   = 1'b0;
	assign in_acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysclk_q   <= tpps_pkg::SYSCLK_RST;
			min_rate_q <= tpps_pkg::MIN_RATE_RST;
			max_rate_q <= tpps_pkg::MAX_RATE_RST;
		end else if (cfg_we) begin
			unique case (tpps_pkg::reg_idx_t'(cfg_index))
				tpps_pkg::REG_SYSCLK:   sysclk_q   <= cfg_wdata;
				tpps_pkg::REG_MIN_RATE: min_rate_q <= cfg_wdata;
				tpps_pkg::REG_MAX_RATE: max_rate_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_range = (req_rate != '0) && (req_rate >= min_rate_q)
		&& (req_rate <= max_rate_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_s1 <= '0;
		end else begin
			entry_s1.vld      <= in_acc;
			entry_s1.in_range <= in_range;
			entry_s1.dividend <= sysclk_q;
			entry_s1.divisor  <= req_rate;
			entry_s1.rem      <= '0;
			entry_s1.quo      <= '0;
		end
	end

	assign chain[0] = entry_s1;

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		tpps_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.stage_in (chain[i]),
			.stage_out(chain[i+1])
		);
	end

	// (clk >> 2k) / rate == (clk / rate) >> 2k, so one quotient serves all codes
	assign quo = chain[N_CELLS].quo;

	always_comb begin
		sel_valid  = chain[N_CELLS].in_range;
		sel_code   = tpps_pkg::PSC_DIV1;
		sel_period = quo[15:0];
		priority if (quo[31:16] == '0) begin
			sel_code   = tpps_pkg::PSC_DIV1;
			sel_period = quo[15:0];
		end else if (quo[31:18] == '0) begin
			sel_code   = tpps_pkg::PSC_DIV4;
			sel_period = quo[17:2];
		end else if (quo[31:20] == '0) begin
			sel_code   = tpps_pkg::PSC_DIV16;
			sel_period = quo[19:4];
		end else if (quo[31:22] == '0) begin
			sel_code   = tpps_pkg::PSC_DIV64;
			sel_period = quo[21:6];
		end else begin
			sel_valid  = 1'b0;
		end
		if (!sel_valid) begin
			sel_code   = tpps_pkg::PSC_DIV1;
			sel_period = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[N_CELLS].vld;
		end
	end

	always_ff @(posedge clk) begin
		valid_q  <= sel_valid;
		code_q   <= sel_code;
		period_q <= sel_period;
	end

	assign done           = done_q;
	assign valid_res      = valid_q;
	assign prescaler_code = code_q;
	assign period_val     = period_q;

`include "timer_prescaler_period_solver_core_assert.svh"

	`TPPS_ASSERT_IMPL(a_fixed_latency, in_acc, ##LATENCY done, "result missing after request")
	`TPPS_ASSERT_IMPL(a_no_spurious, done, $past(in_acc, LATENCY), "result without request")
	`TPPS_ASSERT_NEVER(a_reject_zero,
		done && !valid_res && (prescaler_code != '0 || period_val != '0),
		"rejected result carries nonzero fields")
	`TPPS_ASSERT_IMPL(a_min_code, done && valid_res && prescaler_code != '0,
		period_val[15:14] != '0, "a smaller prescaler would have fit")

endmodule
`default_nettype wire

/* hdl/tpps_div_cell.sv */
`default_nettype none
// One restoring-division step: brings in one dividend bit, yields one quotient bit.
module tpps_div_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tpps_pkg::div_stage_t stage_in,
	output tpps_pkg::div_stage_t    stage_out
);

	tpps_pkg::div_stage_t stage_s1;
	logic [tpps_pkg::DIV_W:0]   trial;
	logic [tpps_pkg::DIV_W:0]   diff;
	logic                       ge;

	always_comb begin
		trial = {stage_in.rem, stage_in.dividend[tpps_pkg::DIV_W-1]};
		diff  = trial - {1'b0, stage_in.divisor};
		ge    = (trial >= {1'b0, stage_in.divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1.vld      <= stage_in.vld;
			stage_s1.in_range <= stage_in.in_range;
			stage_s1.divisor  <= stage_in.divisor;
			stage_s1.dividend <= {stage_in.dividend[tpps_pkg::DIV_W-2:0], 1'b0};
			stage_s1.rem      <= ge ? diff[tpps_pkg::DIV_W-1:0] : trial[tpps_pkg::DIV_W-1:0];
			stage_s1.quo      <= {stage_in.quo[tpps_pkg::DIV_W-2:0], ge};
		end
	end

	assign stage_out = stage_s1;

endmodule
`default_nettype wire
